/* sv/csvp_pkg.sv */
package csvp_pkg;

	localparam int MAX_FIELDS_DEF = 8;
	localparam int LINE_LIMIT_DEF = 511;
	localparam int MAX_DIGITS_DEF = 18;

	localparam int MANT_W = 61;
	localparam int ACC_W  = 60;
	localparam int EXP_W  = 15;
	localparam int EACC_W = 14;

	localparam logic signed [16:0] EXP_MAX = 17'sd16383;
	localparam logic signed [16:0] EXP_MIN = -17'sd16384;

	localparam logic [1:0] ST_FIELD = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [0:0] REG_FIELD_COUNT  = 1'd0;
	localparam logic [0:0] REG_HEADER_LINES = 1'd1;

	typedef enum logic [3:0] {
		PH_HEADER, PH_LEAD, PH_SIGNED, PH_INT, PH_DOT, PH_FRAC,
		PH_EXP, PH_EXPSIGN, PH_EXPDIG, PH_TRAIL, PH_DONE
	} phase_t;

	// one job handed from the parser to the emitter
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] count;
	} job_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [2:0]              field_index;
		logic signed [MANT_W-1:0] mantissa;
		logic signed [EXP_W-1:0]  decimal_exponent;
		logic                    last;
	} result_t;

endpackage

/* sv/csvp_front.sv */
module csvp_front import csvp_pkg::*; #(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF,
	parameter int LINE_LIMIT = LINE_LIMIT_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int FI_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1,
	localparam int LL_W = $clog2(LINE_LIMIT + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_char,
	input  logic                     in_first,
	input  logic [3:0]               field_count,
	input  logic [1:0]               header_lines,
	// job queue side
	output logic                     job_valid,
	output job_t                     job,
	input  logic                     job_ready,
	// field store write port
	output logic                     st_we,
	output logic [FI_W-1:0]          st_addr,
	output logic signed [MANT_W-1:0] st_mant,
	output logic signed [EXP_W-1:0]  st_exp
);

	phase_t           phase_q, ph, ph_n;
	logic [1:0]       hdr_q, hdr, hdr_n;
	logic [ACC_W-1:0] acc_q, acc, acc_n;
	logic [4:0]       sig_q, sig, sig_n;
	logic signed [EXP_W-1:0] adj_q, adj, adj_n;
	logic [EACC_W-1:0] eacc_q, eacc, eacc_n;
	logic [1:0]       sgn_q, sgn, sgn_n;
	logic [FI_W-1:0]  cur_q, cur, cur_n;
	logic [LL_W-1:0]  len_q, len, len_n;
	logic             bad_q, bad, bad_n;
	logic             stop_q, stop, stop_n;

	logic [3:0]       used;
	logic [FI_W-1:0]  last_idx;
	logic             digit, blank, num_end, exp_ch;
	logic [3:0]       d;
	logic             fire, emit;
	job_t             job_n;
	logic             store;
	logic signed [16:0] e_sum;
	logic [17:0]      e_acc10;

	assign fire = in_valid && in_ready;
	assign in_ready = job_ready;

	always_comb begin
		used = field_count;
		if (used == 4'd0) used = 4'd1;
		if (32'(used) > MAX_FIELDS) used = 4'(MAX_FIELDS);
	end
	assign last_idx = FI_W'(used - 4'd1);

	assign digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
	assign blank = (in_char == CH_SP) || (in_char == CH_TAB);
	assign exp_ch = (in_char == CH_LE) || (in_char == CH_UE);
	assign d = digit ? 4'(in_char - CH_ZERO) : 4'd0;

	// store path: field value from current accumulators
	always_comb begin
		e_sum = (sgn[1] ? -17'(signed'({1'b0, eacc})) : 17'(signed'({1'b0, eacc})))
			+ 17'(adj);
		if (e_sum > EXP_MAX) e_sum = EXP_MAX;
		if (e_sum < EXP_MIN) e_sum = EXP_MIN;
		if (acc == '0) e_sum = '0;
		st_addr = cur;
		st_exp  = EXP_W'(e_sum);
		st_mant = sgn[0] ? -signed'({1'b0, acc}) : signed'({1'b0, acc});
	end

	always_comb begin
		// stream start applied first
		ph = phase_q; hdr = hdr_q; acc = acc_q; sig = sig_q; adj = adj_q;
		eacc = eacc_q; sgn = sgn_q; cur = cur_q; len = len_q; bad = bad_q;
		stop = stop_q;
		if (in_first) begin
			acc = '0; sig = '0; adj = '0; eacc = '0; sgn = '0; cur = '0;
			len = '0; bad = 1'b0; stop = 1'b0; hdr = header_lines;
			ph = (header_lines != 2'd0) ? PH_HEADER : PH_LEAD;
		end
		ph_n = ph; hdr_n = hdr; acc_n = acc; sig_n = sig; adj_n = adj;
		eacc_n = eacc; sgn_n = sgn; cur_n = cur; len_n = len; bad_n = bad;
		stop_n = stop;
		emit = 1'b0; job_n = '0; store = 1'b0;
		num_end = (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPDIG) ||
			(ph == PH_TRAIL);
		e_acc10 = 18'(eacc) * 18'd10 + 18'(d);

		if (stop) begin
		end else if (ph == PH_HEADER) begin
			if (in_char == CH_NL) begin
				if (hdr != 2'd0) hdr_n = hdr - 2'd1;
				if (hdr_n == 2'd0) ph_n = PH_LEAD;
			end
		end else if (in_char != CH_NL) begin
			if (32'(len) + 1 >= LINE_LIMIT) begin
				stop_n = 1'b1;
				emit = 1'b1; job_n.status = ST_LONG; job_n.count = 4'd1;
				acc_n = '0; sig_n = '0; adj_n = '0; eacc_n = '0; sgn_n = '0;
				cur_n = '0; len_n = '0; bad_n = 1'b0; ph_n = PH_LEAD;
			end else begin
				len_n = len + LL_W'(1);
				if (!bad && ph != PH_DONE) begin
					if (in_char == CH_COMMA && num_end) begin
						if (cur < last_idx) begin
							store = 1'b1;
							cur_n = cur + FI_W'(1);
							acc_n = '0; sig_n = '0; adj_n = '0; eacc_n = '0;
							sgn_n = '0; ph_n = PH_LEAD;
						end else bad_n = 1'b1;
					end else if ((in_char == CH_CR || in_char == CH_NUL) && num_end)
					begin
						if (cur == last_idx) begin
							store = 1'b1; ph_n = PH_DONE;
						end else bad_n = 1'b1;
					end else begin
						bad_n = 1'b1;
						if ((ph == PH_LEAD || ph == PH_SIGNED || ph == PH_INT ||
							ph == PH_DOT || ph == PH_FRAC) && digit) begin
							bad_n = 1'b0;
							if (sig < 5'(MAX_DIGITS)) begin
								if (acc != '0 || d != 4'd0) begin
									acc_n = ACC_W'(acc * ACC_W'(10)) + ACC_W'(d);
									sig_n = sig + 5'd1;
								end
								if ((ph == PH_DOT || ph == PH_FRAC) && adj != EXP_MIN[14:0])
									adj_n = adj - 15'sd1;
							end else if (ph != PH_DOT && ph != PH_FRAC &&
								adj != EXP_MAX[14:0])
								adj_n = adj + 15'sd1;
							ph_n = (ph == PH_DOT || ph == PH_FRAC) ? PH_FRAC : PH_INT;
						end
						case (ph)
							PH_LEAD: begin
								if (blank) bad_n = 1'b0;
								else if (in_char == CH_MINUS) begin
									sgn_n[0] = 1'b1; ph_n = PH_SIGNED; bad_n = 1'b0;
								end else if (in_char == CH_PLUS) begin
									ph_n = PH_SIGNED; bad_n = 1'b0;
								end else if (in_char == CH_DOT) begin
									ph_n = PH_DOT; bad_n = 1'b0;
								end
							end
							PH_SIGNED: if (in_char == CH_DOT) begin
								ph_n = PH_DOT; bad_n = 1'b0;
							end
							PH_INT: begin
								if (in_char == CH_DOT) begin ph_n = PH_FRAC; bad_n = 1'b0; end
								else if (exp_ch) begin ph_n = PH_EXP; bad_n = 1'b0; end
								else if (blank) begin ph_n = PH_TRAIL; bad_n = 1'b0; end
							end
							PH_FRAC: begin
								if (exp_ch) begin ph_n = PH_EXP; bad_n = 1'b0; end
								else if (blank) begin ph_n = PH_TRAIL; bad_n = 1'b0; end
							end
							PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
								if (ph == PH_EXP && in_char == CH_MINUS) begin
									sgn_n[1] = 1'b1; ph_n = PH_EXPSIGN; bad_n = 1'b0;
								end else if (ph == PH_EXP && in_char == CH_PLUS) begin
									ph_n = PH_EXPSIGN; bad_n = 1'b0;
								end else if (digit) begin
									eacc_n = (e_acc10 > 18'd16383) ? 14'd16383 : 14'(e_acc10);
									ph_n = PH_EXPDIG; bad_n = 1'b0;
								end else if (blank && ph == PH_EXPDIG) begin
									ph_n = PH_TRAIL; bad_n = 1'b0;
								end
							end
							PH_TRAIL: if (blank) bad_n = 1'b0;
							default: ;
						endcase
					end
				end
			end
		end else begin
			// newline ends a data line
			emit = 1'b1;
			if (!bad && ph == PH_DONE) begin
				job_n.status = ST_FIELD; job_n.count = 4'(cur) + 4'd1;
			end else if (!bad && num_end && cur == last_idx) begin
				store = 1'b1;
				job_n.status = ST_FIELD; job_n.count = 4'(cur) + 4'd1;
			end else begin
				job_n.status = ST_BAD; job_n.count = 4'd1;
			end
			acc_n = '0; sig_n = '0; adj_n = '0; eacc_n = '0; sgn_n = '0;
			cur_n = '0; len_n = '0; bad_n = 1'b0; ph_n = PH_LEAD;
		end
	end

	assign st_we = fire && store;
	assign job_valid = fire && emit;
	assign job = job_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hdr_q <= 2'd2; acc_q <= '0; sig_q <= '0;
			adj_q <= '0; eacc_q <= '0; sgn_q <= '0; cur_q <= '0; len_q <= '0;
			bad_q <= 1'b0; stop_q <= 1'b0;
		end else if (fire) begin
			phase_q <= ph_n; hdr_q <= hdr_n; acc_q <= acc_n; sig_q <= sig_n;
			adj_q <= adj_n; eacc_q <= eacc_n; sgn_q <= sgn_n; cur_q <= cur_n;
			len_q <= len_n; bad_q <= bad_n; stop_q <= stop_n;
		end
	end

endmodule

/* sv/csvp_back.sv */
module csvp_back import csvp_pkg::*; #(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF,
	localparam int FI_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	input  job_t                     job,
	output logic                     job_ready,
	input  logic                     st_we,
	input  logic [FI_W-1:0]          st_addr,
	input  logic signed [MANT_W-1:0] st_mant,
	input  logic signed [EXP_W-1:0]  st_exp,
	output logic                     out_valid,
	input  logic                     out_ready,
	output result_t                  out_data
);

	// two banks of field registers: front fills one while the other drains
	logic signed [MANT_W-1:0] mant_q [2][MAX_FIELDS];
	logic signed [EXP_W-1:0]  exp_q  [2][MAX_FIELDS];
	job_t       jobs_q [2];
	logic [1:0] full_q;
	logic       wr_bank_q, rd_bank_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	result_t    out_q;
	logic       take, adv, fin;
	job_t       cj;

	assign job_ready = !full_q[wr_bank_q];
	assign cj = jobs_q[rd_bank_q];
	assign take = full_q[rd_bank_q] && (!out_valid_q || out_ready);
	assign fin = take && (idx_q + 4'd1 == cj.count);
	assign adv = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (st_we) begin
			mant_q[wr_bank_q][st_addr] <= st_mant;
			exp_q[wr_bank_q][st_addr]  <= st_exp;
		end
		if (adv) jobs_q[wr_bank_q] <= job;
		if (take) begin
			out_q.status <= cj.status;
			out_q.field_index <= 3'(idx_q);
			out_q.last <= fin;
			if (cj.status == ST_FIELD) begin
				out_q.mantissa <= mant_q[rd_bank_q][FI_W'(idx_q)];
				out_q.decimal_exponent <= exp_q[rd_bank_q][FI_W'(idx_q)];
			end else begin
				out_q.mantissa <= '0;
				out_q.decimal_exponent <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0; wr_bank_q <= 1'b0; rd_bank_q <= 1'b0;
			idx_q <= '0; out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				full_q[wr_bank_q] <= 1'b1;
				wr_bank_q <= !wr_bank_q;
			end
			if (take) idx_q <= fin ? 4'd0 : idx_q + 4'd1;
			if (fin) begin
				full_q[rd_bank_q] <= 1'b0;
				rd_bank_q <= !rd_bank_q;
			end
			if (take) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* sv/csv_decimal_line_parser_unit.sv */
// CSV decimal line parser.
// Input stream: s_axis_tdata carries one text byte, s_axis_tuser flags the
// first byte of a stream (restarts header skipping, clears stop and any
// partial line). Output stream: one transfer per parsed field of a valid
// line, or a single status transfer for a malformed or too long line;
// m_axis_tlast marks the final transfer caused by a line.
// Configuration: APB registers field_count (0x0) and header_lines (0x4);
// write only while idle. header_lines takes effect at the next stream start.
// Throughput: one byte per cycle while the bank being filled is free.
// Results come from a two-bank field store drained by the back end one
// field per cycle while the receiver accepts. The front refuses bytes
// while the bank it fills still holds a line that has not drained.
// Reset: parser enters header skip with two header lines, field_count 4.
// When the receiver stalls, the output register holds its transfer and
// the banks fill; further bytes are refused once both are full.
module csv_decimal_line_parser_unit import csvp_pkg::*; #(
	parameter int MAX_FIELDS = MAX_FIELDS_DEF,
	parameter int LINE_LIMIT = LINE_LIMIT_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] character
	input  logic         s_axis_tuser,   // [0] first
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,   // [1:0] status, [4:2] field_index,
	                                     // [65:5] mantissa, [80:66] exponent
	output logic         m_axis_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int FI_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	logic [3:0] field_count_q;
	logic [1:0] header_lines_q;
	logic       job_valid, job_ready, st_we;
	job_t       job;
	logic [FI_W-1:0] st_addr;
	logic signed [MANT_W-1:0] st_mant;
	logic signed [EXP_W-1:0]  st_exp;
	result_t    res;

	assign pready = 1'b1;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= 4'd4;
			header_lines_q <= 2'd2;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FIELD_COUNT:  field_count_q <= pwdata[3:0];
				REG_HEADER_LINES: header_lines_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FIELD_COUNT:  prdata = {28'd0, field_count_q};
			REG_HEADER_LINES: prdata = {30'd0, header_lines_q};
			default:          prdata = '0;
		endcase
	end

	csvp_front #(.MAX_FIELDS(MAX_FIELDS), .LINE_LIMIT(LINE_LIMIT),
		.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_char(s_axis_tdata), .in_first(s_axis_tuser),
		.field_count(field_count_q), .header_lines(header_lines_q),
		.job_valid, .job, .job_ready,
		.st_we, .st_addr, .st_mant, .st_exp
	);

	csvp_back #(.MAX_FIELDS(MAX_FIELDS)) u_back (
		.clk, .arst_n,
		.job_valid, .job, .job_ready,
		.st_we, .st_addr, .st_mant, .st_exp,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {7'd0, res.decimal_exponent, res.mantissa, res.field_index,
		res.status};
	assign m_axis_tlast = res.last;

endmodule

/* sv/csvp_checker.sv */
module csvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad status code");
	a_stlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tlast
			&& m_axis_tdata[4:2] == 3'd0)
		else $error("status result not single");
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind csv_decimal_line_parser_unit csvp_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
	.m_axis_tlast, .pready
);

/* tb/csv_decimal_line_parser_unit_tb.sv */
`timescale 1ns / 100ps

module csv_decimal_line_parser_unit_tb;
	import csvp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam logic [60:0] MASK61 = {61{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] character
	logic s_axis_tuser = 1'b0;       // [0] first
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;       // [1:0] status, [4:2] field_index, [65:5] mantissa,
	                                 // [80:66] decimal_exponent
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	csv_decimal_line_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Scoreboard and run statistics
	result_t field_q[$];
	int errors = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int bad_lines = 0;
	int long_lines = 0;
	int burst_left = 0;
	bit sender_idle_on = 1'b1;

	// Parser shadow: configuration and line state
	int cfg_fields = 4;
	int cfg_headers = 2;
	phase_t ph;
	int hdr_left;
	logic [60:0] slot_mant [8];
	logic [14:0] slot_exp [8];
	longint unsigned digits_acc;
	int sig_count;
	int exp_adj;
	int exp_acc;
	bit neg_num, neg_exp;
	int cur_field;
	int line_len;
	bit line_bad;
	bit halted;

	byte line_q[$];

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
	endtask

	function automatic int fields_used();
		int c;
		c = cfg_fields;
		if (c < 1) c = 1;
		if (c > 8) c = 8;
		return c;
	endfunction

	function automatic void clear_number();
		digits_acc = 0;
		sig_count = 0;
		exp_adj = 0;
		exp_acc = 0;
		neg_num = 0;
		neg_exp = 0;
	endfunction

	function automatic void clear_line();
		clear_number();
		cur_field = 0;
		line_len = 0;
		line_bad = 0;
		ph = PH_LEAD;
	endfunction

	function automatic void restart_stream();
		clear_line();
		halted = 0;
		hdr_left = cfg_headers;
		ph = (hdr_left != 0) ? PH_HEADER : PH_LEAD;
	endfunction

	function automatic int sat_exp(int v);
		if (v > 16383) return 16383;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic void take_digit(int d, bit in_frac);
		if (sig_count < MAX_DIGITS_DEF) begin
			if (digits_acc != 0 || d != 0) begin
				digits_acc = digits_acc * 10 + d;
				sig_count++;
			end
			if (in_frac) exp_adj = sat_exp(exp_adj - 1);
		end else if (!in_frac) begin
			exp_adj = sat_exp(exp_adj + 1);
		end
	endfunction

	function automatic void latch_field();
		int e;
		logic [60:0] m;
		if (cur_field >= 8) return;
		e = neg_exp ? -exp_acc : exp_acc;
		e = sat_exp(e + exp_adj);
		m = digits_acc[60:0];
		if (m == 0) e = 0;
		if (neg_num) m = (~m + 61'd1) & MASK61;
		slot_mant[cur_field] = m;
		slot_exp[cur_field] = e[14:0];
	endfunction

	function automatic bit number_ended();
		return ph == PH_INT || ph == PH_FRAC || ph == PH_EXPDIG || ph == PH_TRAIL;
	endfunction

	// Advance the number grammar by one byte of a data line
	function automatic void parse_byte(logic [7:0] c);
		bit dig, blank;
		int d;
		int last_idx;
		int v;
		dig = c >= CH_ZERO && c <= CH_NINE;
		blank = c == CH_SP || c == CH_TAB;
		d = dig ? int'(c - CH_ZERO) : 0;
		last_idx = fields_used() - 1;
		if (ph == PH_DONE) return;
		if (c == CH_COMMA && number_ended()) begin
			if (cur_field < last_idx) begin
				latch_field();
				cur_field++;
				clear_number();
				ph = PH_LEAD;
			end else line_bad = 1;
			return;
		end
		if ((c == CH_CR || c == CH_NUL) && number_ended()) begin
			if (cur_field == last_idx) begin
				latch_field();
				ph = PH_DONE;
			end else line_bad = 1;
			return;
		end
		case (ph)
			PH_LEAD, PH_SIGNED: begin
				if (ph == PH_LEAD && blank) return;
				if (ph == PH_LEAD && c == CH_MINUS) begin
					neg_num = 1; ph = PH_SIGNED; return;
				end
				if (ph == PH_LEAD && c == CH_PLUS) begin
					ph = PH_SIGNED; return;
				end
				if (dig) begin
					take_digit(d, 0); ph = PH_INT; return;
				end
				if (c == CH_DOT) begin
					ph = PH_DOT; return;
				end
			end
			PH_INT: begin
				if (dig) begin
					take_digit(d, 0); return;
				end
				if (c == CH_DOT) begin
					ph = PH_FRAC; return;
				end
				if (c == CH_LE || c == CH_UE) begin
					ph = PH_EXP; return;
				end
				if (blank) begin
					ph = PH_TRAIL; return;
				end
			end
			PH_DOT: begin
				if (dig) begin
					take_digit(d, 1); ph = PH_FRAC; return;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					take_digit(d, 1); return;
				end
				if (c == CH_LE || c == CH_UE) begin
					ph = PH_EXP; return;
				end
				if (blank) begin
					ph = PH_TRAIL; return;
				end
			end
			PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
				if (ph == PH_EXP && c == CH_MINUS) begin
					neg_exp = 1; ph = PH_EXPSIGN; return;
				end
				if (ph == PH_EXP && c == CH_PLUS) begin
					ph = PH_EXPSIGN; return;
				end
				if (dig) begin
					v = exp_acc * 10 + d;
					exp_acc = (v > 16383) ? 16383 : v;
					ph = PH_EXPDIG;
					return;
				end
				if (blank && ph == PH_EXPDIG) begin
					ph = PH_TRAIL; return;
				end
			end
			PH_TRAIL: begin
				if (blank) return;
			end
			default: ;
		endcase
		line_bad = 1;
	endfunction

	function automatic void queue_status(logic [1:0] st);
		result_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		field_q.push_back(r);
	endfunction

	// Predict the results of one accepted byte
	function automatic void predict_byte(logic [7:0] c, bit first);
		bit ok;
		int n;
		result_t r;
		if (first) restart_stream();
		if (halted) return;
		if (ph == PH_HEADER) begin
			if (c == CH_NL) begin
				if (hdr_left != 0) hdr_left--;
				if (hdr_left == 0) ph = PH_LEAD;
			end
			return;
		end
		if (c != CH_NL) begin
			if (line_len + 1 >= LINE_LIMIT_DEF) begin
				halted = 1;
				clear_line();
				queue_status(ST_LONG);
				long_lines++;
				return;
			end
			line_len++;
			if (!line_bad) parse_byte(c);
			return;
		end
		ok = 0;
		if (!line_bad) begin
			if (ph == PH_DONE) ok = 1;
			else if (number_ended() && cur_field == fields_used() - 1) begin
				latch_field();
				ok = 1;
			end
		end
		if (!ok) begin
			clear_line();
			queue_status(ST_BAD);
			bad_lines++;
			return;
		end
		n = (cur_field + 1 > 8) ? 8 : cur_field + 1;
		for (int i = 0; i < n; i++) begin
			r.status = ST_FIELD;
			r.field_index = i[2:0];
			r.mantissa = slot_mant[i];
			r.decimal_exponent = slot_exp[i];
			r.last = (i + 1 == n);
			field_q.push_back(r);
		end
		clear_line();
	endfunction

	// Check every output transfer against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (field_q.size() == 0) begin
				report_mismatch("unexpected transfer, status", m_axis_tdata[1:0], -1);
			end else begin
				want = field_q.pop_front();
				if (m_axis_tdata[1:0] != want.status)
					report_mismatch("status", m_axis_tdata[1:0], want.status);
				if (m_axis_tdata[4:2] != want.field_index)
					report_mismatch("field_index", m_axis_tdata[4:2], want.field_index);
				if (m_axis_tdata[65:5] != want.mantissa)
					report_mismatch("mantissa", $signed(m_axis_tdata[65:5]), want.mantissa);
				if (m_axis_tdata[80:66] != want.decimal_exponent)
					report_mismatch("decimal_exponent", $signed(m_axis_tdata[80:66]),
						want.decimal_exponent);
				if (m_axis_tlast != want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	// Receiver: stall pattern steps through four modes in turn
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 48) % 4;
		case (mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= ((cycles % 6) < 4);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Send one byte; the sender works in bursts with random gaps between them
	task automatic send_byte(logic [7:0] c, bit first);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (sender_idle_on && $urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= first;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_byte(c, first);
		bytes_sent++;
	endtask

	// Transfer the assembled line, with first on its first byte if asked
	task automatic send_line(bit first);
		foreach (line_q[i]) send_byte(line_q[i], first && i == 0);
		line_q.delete();
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endfunction

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (field_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == 3'(4 * REG_FIELD_COUNT)) cfg_fields = data[3:0];
		else cfg_headers = data[1:0];
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(int fc, int hc);
		drain();
		reg_write(3'(4 * REG_FIELD_COUNT), fc);
		reg_write(3'(4 * REG_HEADER_LINES), hc);
	endtask

	// Header lines of noise, first on the first byte; with no header lines
	// nothing is sent and setting first is left to the caller
	task automatic open_stream();
		for (int h = 0; h < cfg_headers; h++) begin
			repeat ($urandom_range(0, 6)) put_text(" ");
			repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(11, 255)));
			line_q.push_back(CH_NL);
			send_line(h == 0);
		end
	endtask

	function automatic void put_digits(int n);
		repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void put_number();
		int ni, nf;
		repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
		case ($urandom_range(0, 3))
			0: line_q.push_back(CH_MINUS);
			1: line_q.push_back(CH_PLUS);
			default: ;
		endcase
		ni = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 4);
		if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(CH_ZERO);
		put_digits(ni);
		if (ni == 0 || $urandom_range(0, 1)) begin
			line_q.push_back(CH_DOT);
			nf = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 4);
			if (ni == 0 && nf == 0) nf = 1;
			put_digits(nf);
		end
		if ($urandom_range(0, 2) == 0) begin
			line_q.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
			case ($urandom_range(0, 2))
				0: line_q.push_back(CH_MINUS);
				1: line_q.push_back(CH_PLUS);
				default: ;
			endcase
			put_digits($urandom_range(1, 6));
		end
		repeat ($urandom_range(0, 1)) line_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
	endfunction

	// Mostly well formed lines with random content; the rest broken or noise
	task automatic random_line();
		int n, kind, pos;
		kind = $urandom_range(0, 19);
		n = fields_used();
		if (kind == 0) n = n + 1;
		if (kind == 1 && n > 1) n = n - 1;
		if (kind == 2) begin
			repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			for (int f = 0; f < n; f++) begin
				if (f != 0) line_q.push_back(CH_COMMA);
				put_number();
			end
			if (kind == 3 || kind == 4) begin
				line_q.push_back(CH_CR);
				repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(11, 255)));
			end
			if (kind == 5) line_q.push_back(CH_NUL);
			if (kind == 6) begin
				pos = $urandom_range(0, line_q.size() - 1);
				line_q[pos] = 8'($urandom_range(0, 255));
			end
		end
		line_q.push_back(CH_NL);
		send_line(1'b0);
	endtask

	task automatic test_directed();
		configure(1, 0);
		put_text("0\n");
		send_line(1'b1);
		put_text("-0.000\n");                                 send_line(1'b0);
		put_text("999999999999999999999\n");                  send_line(1'b0);
		put_text("-123456789012345678.9\n");                  send_line(1'b0);
		put_text("0.0000000000000000000001234\n");            send_line(1'b0);
		put_text("1e99999\n");                                send_line(1'b0);
		put_text("-1.5E-99999\n");                            send_line(1'b0);
		put_text("+.5\n");                                    send_line(1'b0);
		put_text(" \t7 \r junk,,\n");                         send_line(1'b0);
		put_text("5"); line_q.push_back(CH_NUL); put_text("x\n"); send_line(1'b0);
		put_text("1.\n");                                     send_line(1'b0);
		put_text("\n");                                       send_line(1'b0);
		put_text("1,2\n");                                    send_line(1'b0);
		put_text("e5\n");                                     send_line(1'b0);
		put_text("3e\n");                                     send_line(1'b0);
		line_q.push_back(8'hFF); put_text("\n");              send_line(1'b0);
		configure(8, 3);
		open_stream();
		put_text("1,-2,+3.5,4e2,.5,6E-1,0,-999999999999999999\n");
		send_line(1'b0);
		put_text("1,2,3,4,5,6,7,8,9\n");                      send_line(1'b0);
		put_text("1,2,3\r\n");                                send_line(1'b0);
	endtask

	// Line length limit: a line that reaches the limit without a newline
	// stops the stream until first comes again
	task automatic test_line_limit();
		configure(1, 0);
		sender_idle_on = 1'b0;
		repeat (LINE_LIMIT_DEF) put_text("1");
		put_text("\n2\n");
		send_line(1'b1);
		sender_idle_on = 1'b1;
		put_text("4\n");
		send_line(1'b1);
	endtask

	task automatic test_random();
		int fc_set [6] = '{1, 8, 3, 0, 15, 5};
		int start;
		foreach (fc_set[p]) begin
			configure(fc_set[p], (p == 1) ? 3 : $urandom_range(0, 3));
			open_stream();
			start = bytes_sent;
			sender_idle_on = (p != 2);
			while (bytes_sent < start + 20) begin
				if (cfg_headers == 0 && line_q.size() == 0 && $urandom_range(0, 15) == 0) begin
					line_q.push_back(8'($urandom_range(0, 255)));
					send_line(1'b1);
				end
				random_line();
			end
		end
		sender_idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			slot_mant[i] = '0;
			slot_exp[i] = '0;
		end
		restart_stream();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_line_limit();
		test_random();
		drain();
		$display("Sent %0d bytes over %0d cycles; checked %0d results", bytes_sent, cycles,
			results_seen);
		$display("Malformed lines %0d, too long lines %0d", bad_lines, long_lines);
		if (errors == 0 && field_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
